### src/hrp_pkg.sv
// Shared types, codes and constants of the HTTP request header parser.
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

   // default sizes
   localparam int METHOD_BYTES_DEF      = 16;
   localparam int PATH_BYTES_DEF        = 256;
   localparam int MAX_REQUEST_BYTES_DEF = 65536;

   // result beat layout
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 2;

   // result kinds
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_METHOD  = 2'd1;
   localparam logic [1:0] KIND_PATH    = 2'd2;
   localparam logic [1:0] KIND_SUMMARY = 2'd3;

   // summary status
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_METHOD = 2'd1;
   localparam logic [1:0] ST_BAD_PATH   = 2'd2;
   localparam logic [1:0] ST_INCOMPLETE = 2'd3;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [23:0] BLANK_TAIL = 24'h0D0A0D;

   // header name matching
   localparam int NAME_LEN = 15;
   localparam int MIN_LINE = 17;

   typedef enum logic [1:0] {
      PH_METHOD,
      PH_PATH,
      PH_REST,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      LM_WAIT_LF,
      LM_IN_LINE,
      LM_SKIP
   } line_mode_type;

   typedef enum logic [1:0] {
      NP_SPACE,
      NP_DIGITS,
      NP_NEG,
      NP_STOP
   } number_phase_type;

   // control from the request parser to the line scanner
   typedef struct packed {
      logic step;     // run this byte through the line logic
      logic restart;  // new request: start from the reset state
   } line_ctrl_type;

   // lower-case "content-length:" one character at a time
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h63;  // c
         4'd1:    c = 8'h6F;  // o
         4'd2:    c = 8'h6E;  // n
         4'd3:    c = 8'h74;  // t
         4'd4:    c = 8'h65;  // e
         4'd5:    c = 8'h6E;  // n
         4'd6:    c = 8'h74;  // t
         4'd7:    c = 8'h2D;  // -
         4'd8:    c = 8'h6C;  // l
         4'd9:    c = 8'h65;  // e
         4'd10:   c = 8'h6E;  // n
         4'd11:   c = 8'h67;  // g
         4'd12:   c = 8'h74;  // t
         4'd13:   c = 8'h68;  // h
         4'd14:   c = 8'h3A;  // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // whitespace as strtol sees it, minus CR
   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
             (b == CH_VT) || (b == CH_FF);
   endfunction

endpackage

`default_nettype wire

### src/hrp_line_scan.sv
// Header line scanner: finds Content-Length lines and converts their value.
`timescale 1ns / 1ps
`default_nettype none

module hrp_line_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hrp_pkg::line_ctrl_type ctrl,
   input  wire logic [7:0]            data_byte,
   output logic [31:0]                body_length
);

   hrp_pkg::line_mode_type    mode_ff, mode_in, mode_e;
   hrp_pkg::number_phase_type np_ff, np_in, np_e;
   logic [7:0]  pos_ff, pos_in, pos_e;
   logic        match_ff, match_in, match_e;
   logic [31:0] cand_ff, cand_in, cand_e;
   logic [31:0] len_ff, len_in, len_e;

   logic [7:0]  lc;
   logic        digit;
   logic [35:0] cand_x10;

   // state as seen by this beat: a new request starts from reset values
   assign mode_e  = ctrl.restart ? hrp_pkg::LM_WAIT_LF : mode_ff;
   assign np_e    = ctrl.restart ? hrp_pkg::NP_SPACE : np_ff;
   assign pos_e   = ctrl.restart ? 8'd0 : pos_ff;
   assign match_e = ctrl.restart ? 1'b0 : match_ff;
   assign cand_e  = ctrl.restart ? 32'd0 : cand_ff;
   assign len_e   = ctrl.restart ? 32'd0 : len_ff;

   // byte helpers
   assign lc = ((data_byte >= hrp_pkg::CH_UP_A) && (data_byte <= hrp_pkg::CH_UP_Z))
             ? data_byte + 8'd32 : data_byte;
   assign digit = (data_byte >= hrp_pkg::CH_ZERO) && (data_byte <= hrp_pkg::CH_NINE);
   assign cand_x10 = ({4'd0, cand_e} << 3) + ({4'd0, cand_e} << 1)
                   + {32'd0, data_byte[3:0]};

   // next state
   always_comb begin
      mode_in  = mode_e;
      np_in    = np_e;
      pos_in   = pos_e;
      match_in = match_e;
      cand_in  = cand_e;
      len_in   = len_e;
      if (ctrl.step) begin
         unique case (mode_e)
            hrp_pkg::LM_WAIT_LF: begin
               if (data_byte == hrp_pkg::CH_LF) begin
                  mode_in  = hrp_pkg::LM_IN_LINE;
                  pos_in   = 8'd0;
                  match_in = 1'b1;
                  np_in    = hrp_pkg::NP_SPACE;
                  cand_in  = 32'd0;
               end
            end
            hrp_pkg::LM_SKIP: begin
               // byte after CR is swallowed, next line starts
               mode_in  = hrp_pkg::LM_IN_LINE;
               pos_in   = 8'd0;
               match_in = 1'b1;
               np_in    = hrp_pkg::NP_SPACE;
               cand_in  = 32'd0;
            end
            hrp_pkg::LM_IN_LINE: begin
               if (data_byte == hrp_pkg::CH_CR) begin
                  if (match_e && (pos_e >= 8'(hrp_pkg::MIN_LINE))) len_in = cand_e;
                  mode_in = hrp_pkg::LM_SKIP;
               end else begin
                  if (pos_e < 8'(hrp_pkg::NAME_LEN)) begin
                     if (lc != hrp_pkg::name_char(pos_e[3:0])) match_in = 1'b0;
                  end else if (match_e) begin
                     // strtol-style number
                     case (np_e)
                        hrp_pkg::NP_SPACE: begin
                           if (hrp_pkg::is_blank(data_byte)) begin
                              np_in = hrp_pkg::NP_SPACE;
                           end else if (data_byte == hrp_pkg::CH_PLUS) begin
                              np_in = hrp_pkg::NP_DIGITS;
                           end else if (data_byte == hrp_pkg::CH_MINUS) begin
                              np_in = hrp_pkg::NP_NEG;
                           end else if (digit) begin
                              cand_in = {28'd0, data_byte[3:0]};
                              np_in   = hrp_pkg::NP_DIGITS;
                           end else begin
                              np_in = hrp_pkg::NP_STOP;
                           end
                        end
                        hrp_pkg::NP_DIGITS: begin
                           if (digit) begin
                              cand_in = (cand_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                  : cand_x10[31:0];
                           end else begin
                              np_in = hrp_pkg::NP_STOP;
                           end
                        end
                        default: np_in = np_e;
                     endcase
                  end
                  if (pos_e != 8'd255) pos_in = pos_e + 8'd1;
               end
            end
            default: mode_in = mode_e;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= hrp_pkg::LM_WAIT_LF;
         np_ff    <= hrp_pkg::NP_SPACE;
         pos_ff   <= 8'd0;
         match_ff <= 1'b0;
         cand_ff  <= 32'd0;
         len_ff   <= 32'd0;
      end else begin
         mode_ff  <= mode_in;
         np_ff    <= np_in;
         pos_ff   <= pos_in;
         match_ff <= match_in;
         cand_ff  <= cand_in;
         len_ff   <= len_in;
      end
   end

   assign body_length = len_ff;

endmodule

`default_nettype wire

### src/http_request_header_parser_top.sv
// Top level of the HTTP request header parser.
// Takes one request byte per beat and returns exactly one result beat per byte:
// a method or path echo, a header summary, or a "nothing" beat. Every byte is
// handled between the request handshake and the result register, so the
// block sustains one byte per clock while results drain; a result appears in
// the cycle after its byte is taken. The only stall comes from the result side:
// req_tready is high whenever the result register is empty or being drained.
// The state is a handful of counters plus the line scanner, so no warm-up or
// clearing pass follows reset. A first_byte flag restarts parsing on that byte.
`timescale 1ns / 1ps
`default_nettype none

module http_request_header_parser_top #(
   parameter int METHOD_BYTES      = hrp_pkg::METHOD_BYTES_DEF,
   parameter int PATH_BYTES        = hrp_pkg::PATH_BYTES_DEF,
   parameter int MAX_REQUEST_BYTES = hrp_pkg::MAX_REQUEST_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]  req_tuser,   // [0] first_byte
   input  wire logic        req_tlast,   // end_of_data
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [hrp_pkg::RSP_DATA_W-1:0] rsp_tdata,
      // [7:0] echo_byte, [9:8] status, [13:10] method_length,
      // [21:14] path_length, [53:22] body_length, [69:54] header_length, rest 0
   output logic [hrp_pkg::RSP_USER_W-1:0] rsp_tuser   // [1:0] kind
);

   localparam int MC_W = $clog2(METHOD_BYTES + 1);
   localparam int PC_W = $clog2(PATH_BYTES + 1);
   localparam int BC_W = $clog2(MAX_REQUEST_BYTES + 1);

   hrp_pkg::phase_type phase_ff, phase_in, phase_e;
   logic [23:0]     tail_ff, tail_in, tail_e;
   logic [MC_W-1:0] mcount_ff, mcount_in, mcount_e;
   logic [PC_W-1:0] pcount_ff, pcount_in, pcount_e;
   logic [BC_W-1:0] bcount_ff, bcount_in, bcount_e, bcount_inc;
   logic [1:0]      err_ff, err_in, err_e;

   logic            rsp_valid_ff;
   logic [1:0]      kind_ff, kind_in;
   logic [7:0]      echo_ff, echo_in;
   logic [1:0]      status_ff, status_in;
   logic [3:0]      mlen_ff, mlen_in;
   logic [7:0]      plen_ff, plen_in;
   logic [31:0]     body_ff, body_in;
   logic [15:0]     hlen_ff, hlen_in;

   logic            accept, first, eod, active, hdr_end, overflow;
   logic [7:0]      b;
   logic [31:0]     body_length;
   hrp_pkg::line_ctrl_type line_ctrl;

   assign accept = req_tvalid && req_tready;
   assign b      = req_tdata;
   assign first  = req_tuser[0];
   assign eod    = req_tlast;

   // state seen by this beat; first_byte restarts from reset values
   assign phase_e  = first ? hrp_pkg::PH_METHOD : phase_ff;
   assign tail_e   = first ? 24'd0 : tail_ff;
   assign mcount_e = first ? '0 : mcount_ff;
   assign pcount_e = first ? '0 : pcount_ff;
   assign bcount_e = first ? '0 : bcount_ff;
   assign err_e    = first ? hrp_pkg::ST_BAD_METHOD : err_ff;

   // per-byte conditions
   assign active     = accept && (phase_e != hrp_pkg::PH_DONE);
   assign bcount_inc = (bcount_e < BC_W'(MAX_REQUEST_BYTES)) ? bcount_e + 1'b1 : bcount_e;
   assign hdr_end    = (b == hrp_pkg::CH_LF) && (tail_e == hrp_pkg::BLANK_TAIL);
   assign overflow   = eod || (bcount_inc >= BC_W'(MAX_REQUEST_BYTES));

   assign line_ctrl.step    = active && !hdr_end;
   assign line_ctrl.restart = accept && first;

   hrp_line_scan u_line_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (line_ctrl),
      .data_byte   (b),
      .body_length (body_length)
   );

   // next state
   always_comb begin
      phase_in  = phase_ff;
      tail_in   = tail_ff;
      mcount_in = mcount_ff;
      pcount_in = pcount_ff;
      bcount_in = bcount_ff;
      err_in    = err_ff;
      if (accept) begin
         phase_in  = phase_e;
         tail_in   = tail_e;
         mcount_in = mcount_e;
         pcount_in = pcount_e;
         bcount_in = bcount_e;
         err_in    = err_e;
      end
      if (active) begin
         bcount_in = bcount_inc;
         tail_in   = {tail_e[15:0], b};
         if (hdr_end) begin
            phase_in = hrp_pkg::PH_DONE;
         end else begin
            unique case (phase_e)
               hrp_pkg::PH_METHOD: begin
                  if (b == hrp_pkg::CH_SPACE) begin
                     if (mcount_e >= MC_W'(METHOD_BYTES)) begin
                        phase_in = hrp_pkg::PH_REST;
                     end else begin
                        err_in   = hrp_pkg::ST_BAD_PATH;
                        phase_in = hrp_pkg::PH_PATH;
                     end
                  end else if (mcount_e < MC_W'(METHOD_BYTES)) begin
                     mcount_in = mcount_e + 1'b1;
                  end
               end
               hrp_pkg::PH_PATH: begin
                  if (b == hrp_pkg::CH_SPACE) begin
                     if (pcount_e < PC_W'(PATH_BYTES)) err_in = hrp_pkg::ST_OK;
                     phase_in = hrp_pkg::PH_REST;
                  end else if (pcount_e < PC_W'(PATH_BYTES)) begin
                     pcount_in = pcount_e + 1'b1;
                  end
               end
               default: phase_in = phase_e;
            endcase
            if (overflow) phase_in = hrp_pkg::PH_DONE;
         end
      end
   end

   // result fields
   always_comb begin
      kind_in   = hrp_pkg::KIND_NONE;
      echo_in   = 8'd0;
      status_in = hrp_pkg::ST_OK;
      mlen_in   = 4'd0;
      plen_in   = 8'd0;
      body_in   = 32'd0;
      hlen_in   = 16'd0;
      if (active) begin
         if (hdr_end) begin
            kind_in   = hrp_pkg::KIND_SUMMARY;
            status_in = err_e;
            if (err_e == hrp_pkg::ST_OK) begin
               mlen_in = 4'(mcount_e);
               plen_in = 8'(pcount_e);
               body_in = body_length;
            end
            hlen_in = (32'(bcount_inc) > 32'd65535) ? 16'hFFFF : 16'(bcount_inc);
         end else if (overflow) begin
            kind_in   = hrp_pkg::KIND_SUMMARY;
            status_in = hrp_pkg::ST_INCOMPLETE;
         end else if ((phase_e == hrp_pkg::PH_METHOD) && (b != hrp_pkg::CH_SPACE)) begin
            kind_in = hrp_pkg::KIND_METHOD;
            echo_in = b;
         end else if ((phase_e == hrp_pkg::PH_PATH) && (b != hrp_pkg::CH_SPACE)) begin
            kind_in = hrp_pkg::KIND_PATH;
            echo_in = b;
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrp_pkg::PH_METHOD;
         tail_ff   <= 24'd0;
         mcount_ff <= '0;
         pcount_ff <= '0;
         bcount_ff <= '0;
         err_ff    <= hrp_pkg::ST_BAD_METHOD;
      end else begin
         phase_ff  <= phase_in;
         tail_ff   <= tail_in;
         mcount_ff <= mcount_in;
         pcount_ff <= pcount_in;
         bcount_ff <= bcount_in;
         err_ff    <= err_in;
      end
   end

   // result register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register: payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         echo_ff   <= echo_in;
         status_ff <= status_in;
         mlen_ff   <= mlen_in;
         plen_ff   <= plen_in;
         body_ff   <= body_in;
         hlen_ff   <= hlen_in;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {2'b00, hlen_ff, body_ff, plen_ff, mlen_ff, status_ff, echo_ff};

endmodule

`default_nettype wire

### src/hrp_checker.sv
// Port-level checks of the header parser and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hrp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [hrp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [hrp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // every byte taken yields a result beat next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted byte without result");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // echo beats carry nothing but the byte
   a_echo_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == hrp_pkg::KIND_METHOD || rsp_tuser == hrp_pkg::KIND_PATH))
      |-> (rsp_tdata[71:8] == 64'd0))
      else $error("echo beat with summary fields");

   // empty and summary beats carry no echo byte
   a_no_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == hrp_pkg::KIND_NONE || rsp_tuser == hrp_pkg::KIND_SUMMARY))
      |-> (rsp_tdata[7:0] == 8'd0))
      else $error("echo byte on non-echo beat");

endmodule

bind http_request_header_parser_top hrp_checker u_hrp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the HTTP request header parser top level.
`timescale 1ns / 1ps

module testbench;
   import hrp_pkg::*;

   // Tracks the parser state per accepted byte and holds the result beats it predicts
   class http_header_tracker;
      typedef struct packed {
         logic [1:0]  kind;
         logic [7:0]  echo;
         logic [1:0]  status;
         logic [3:0]  method_len;
         logic [7:0]  path_len;
         logic [31:0] content_len;
         logic [15:0] header_len;
      } parse_beat_t;

      parse_beat_t      parsed_beats[$];
      int unsigned      mismatches;
      int unsigned      beats_seen;
      string            length_name = "content-length:";

      phase_type        req_phase;
      line_mode_type    line_mode;
      number_phase_type num_phase;
      logic [23:0]      tail;
      logic [4:0]       method_count;
      logic [8:0]       path_count;
      logic [7:0]       line_pos;
      logic             name_ok;
      logic [32:0]      candidate;
      logic [32:0]      body_value;
      logic [16:0]      byte_count;
      logic [1:0]       err_code;

      function new();
         restart();
      endfunction

      function void restart();
         req_phase    = PH_METHOD;
         line_mode    = LM_WAIT_LF;
         num_phase    = NP_SPACE;
         tail         = '0;
         method_count = '0;
         path_count   = '0;
         line_pos     = '0;
         name_ok      = 1'b0;
         candidate    = '0;
         body_value   = '0;
         byte_count   = '0;
         err_code     = ST_BAD_METHOD;
      endfunction

      function void start_line();
         line_mode = LM_IN_LINE;
         line_pos  = '0;
         name_ok   = 1'b1;
         num_phase = NP_SPACE;
         candidate = '0;
      endfunction

      function int unsigned pending();
         return parsed_beats.size();
      endfunction

      // Predict the result beat for one accepted request byte
      function void parse_byte(logic [7:0] b, logic first, logic eod);
         parse_beat_t r;
         logic        hdr_end;
         logic        digit;
         logic [7:0]  lc;
         logic [63:0] grown;
         r = '0;
         if (first) restart();
         if (req_phase == PH_DONE) begin
            parsed_beats.push_back(r);
            return;
         end
         if (byte_count < MAX_REQUEST_BYTES_DEF) byte_count++;
         hdr_end = (b == CH_LF) && (tail == BLANK_TAIL);
         tail = {tail[15:0], b};

         // blank line: summary takes the place of the final LF
         if (hdr_end) begin
            r.kind   = KIND_SUMMARY;
            r.status = err_code;
            if (err_code == ST_OK) begin
               r.method_len  = method_count[3:0];
               r.path_len    = path_count[7:0];
               r.content_len = body_value[31:0];
            end
            r.header_len = (byte_count > 17'd65535) ? 16'hFFFF : byte_count[15:0];
            req_phase = PH_DONE;
            parsed_beats.push_back(r);
            return;
         end

         // request line: method and path echo
         case (req_phase)
            PH_METHOD: begin
               if (b == CH_SPACE) begin
                  if (method_count >= METHOD_BYTES_DEF) begin
                     req_phase = PH_REST;
                  end else begin
                     err_code  = ST_BAD_PATH;
                     req_phase = PH_PATH;
                  end
               end else begin
                  r.kind = KIND_METHOD;
                  r.echo = b;
                  if (method_count < METHOD_BYTES_DEF) method_count++;
               end
            end
            PH_PATH: begin
               if (b == CH_SPACE) begin
                  if (path_count < PATH_BYTES_DEF) err_code = ST_OK;
                  req_phase = PH_REST;
               end else begin
                  r.kind = KIND_PATH;
                  r.echo = b;
                  if (path_count < PATH_BYTES_DEF) path_count++;
               end
            end
            default: ;
         endcase

         // header line scan for the body length
         if (line_mode == LM_WAIT_LF) begin
            if (b == CH_LF) start_line();
         end else if (line_mode == LM_SKIP) begin
            start_line();
         end else if (b == CH_CR) begin
            if (name_ok && line_pos >= MIN_LINE) body_value = candidate;
            line_mode = LM_SKIP;
         end else begin
            if (line_pos < NAME_LEN) begin
               lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
               if (lc != length_name[line_pos]) name_ok = 1'b0;
            end else if (name_ok) begin
               digit = (b >= CH_ZERO) && (b <= CH_NINE);
               case (num_phase)
                  NP_SPACE: begin
                     if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
                         b == CH_FF) begin
                        num_phase = NP_SPACE;
                     end else if (b == CH_PLUS) begin
                        num_phase = NP_DIGITS;
                     end else if (b == CH_MINUS) begin
                        num_phase = NP_NEG;
                     end else if (digit) begin
                        candidate = {25'd0, b - CH_ZERO};
                        num_phase = NP_DIGITS;
                     end else begin
                        num_phase = NP_STOP;
                     end
                  end
                  NP_DIGITS: begin
                     if (digit) begin
                        grown = {31'd0, candidate} * 64'd10 + {56'd0, b - CH_ZERO};
                        candidate = (grown > 64'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : grown[32:0];
                     end else begin
                        num_phase = NP_STOP;
                     end
                  end
                  default: ;
               endcase
            end
            if (line_pos < 8'd255) line_pos++;
         end

         // end of data or full buffer overrides any echo
         if (eod || byte_count >= MAX_REQUEST_BYTES_DEF) begin
            r        = '0;
            r.kind   = KIND_SUMMARY;
            r.status = ST_INCOMPLETE;
            req_phase = PH_DONE;
         end
         parsed_beats.push_back(r);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("MISMATCH beat %0d: %s", beats_seen, msg);
      endtask

      task compare(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", what, got, want));
      endtask

      // Check one result beat against the oldest prediction
      task check_beat(logic [RSP_DATA_W-1:0] d, logic [RSP_USER_W-1:0] u);
         parse_beat_t w;
         beats_seen++;
         if (parsed_beats.size() == 0) begin
            report($sformatf("unexpected beat kind %0d data 0x%0h", u, d));
            return;
         end
         w = parsed_beats.pop_front();
         compare("kind", u, w.kind);
         compare("echo_byte", d[7:0], w.echo);
         compare("status", d[9:8], w.status);
         compare("method_length", d[13:10], w.method_len);
         compare("path_length", d[21:14], w.path_len);
         compare("body_length", d[53:22], w.content_len);
         compare("header_length", d[69:54], w.header_len);
         compare("pad", d[71:70], 2'b00);
      endtask
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic [0:0]            req_tuser  = 1'b0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   http_header_tracker tracker = new();

   // request bytes waiting to go out: {end_of_data, first_byte, data_byte}
   logic [9:0]  outgoing[$];
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served  = 0;
   int unsigned hold_left     = 0;

   http_request_header_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("http_request_header_parser_top regression: fail");
      $finish;
   end

   // observe both handshakes at each edge: prediction first, then the check
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.parse_byte(req_tdata, req_tuser[0], req_tlast);
         if (rsp_tvalid && rsp_tready) tracker.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= 400;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic add_byte(logic [7:0] b, bit first = 1'b0, bit eod = 1'b0);
      outgoing.push_back({eod, first, b});
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] maybe_noise(logic [7:0] c);
      return ($urandom_range(99) < 4) ? 8'($urandom) : c;
   endfunction

   // One header line: mostly Content-Length in many shapes, else other or junk lines
   task automatic add_header_line();
      int unsigned pick;
      int unsigned n;
      string       name;
      logic [7:0]  c;
      name = "content-length:";
      pick = $urandom_range(99);
      if (pick < 55) begin
         for (int i = 0; i < name.len(); i++) begin
            c = name[i];
            if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
            add_byte(maybe_noise(c));
         end
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(4))
               0:       c = CH_SPACE;
               1:       c = CH_TAB;
               2:       c = CH_VT;
               3:       c = CH_FF;
               default: c = CH_LF;
            endcase
            add_byte(c);
         end
         pick = $urandom_range(99);
         if (pick < 15) add_byte(CH_PLUS);
         else if (pick < 30) add_byte(CH_MINUS);
         pick = $urandom_range(99);
         if (pick < 4) begin
            add_text("4294967295");
         end else if (pick < 8) begin
            add_text("4294967296");
         end else begin
            n = (pick < 35) ? $urandom_range(0, 2) :
                (pick < 75) ? $urandom_range(1, 5) : $urandom_range(9, 12);
            repeat (n) add_byte(CH_ZERO + 8'($urandom_range(9)));
         end
         if ($urandom_range(99) < 20) add_byte(8'($urandom));
      end else if (pick < 85) begin
         add_text("Host: ");
         repeat ($urandom_range(1, 6)) add_byte(maybe_noise("a" + 8'($urandom_range(25))));
      end else begin
         repeat ($urandom_range(0, 20)) add_byte(8'($urandom));
      end
      add_text("\r\n");
   endtask

   // A mostly well-formed request with random content; some are cut or broken
   task automatic add_request();
      int unsigned start;
      int unsigned pick;
      int unsigned n;
      start = outgoing.size();
      pick  = $urandom_range(99);
      n = (pick < 12) ? $urandom_range(14, 18) : (pick < 16) ? 0 : $urandom_range(1, 7);
      repeat (n) add_byte(maybe_noise(CH_UP_A + 8'($urandom_range(25))));
      if ($urandom_range(99) >= 4) add_byte(CH_SPACE);
      add_byte("/");
      repeat ($urandom_range(0, 10)) add_byte(maybe_noise("a" + 8'($urandom_range(25))));
      if ($urandom_range(99) >= 4) add_byte(CH_SPACE);
      if ($urandom_range(99) < 70) add_text("HTTP/1.1");
      add_text("\r\n");
      repeat ($urandom_range(0, 4)) add_header_line();
      pick = $urandom_range(99);
      if (pick < 80) begin
         add_text("\r\n");
      end else if (pick < 90) begin
         if ($urandom_range(1)) outgoing[outgoing.size() - 1][9] = 1'b1;
      end else begin
         add_text("\r\n");
         repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
      if ($urandom_range(99) < 8) outgoing[$urandom_range(start, outgoing.size() - 1)][9] = 1'b1;
      outgoing[start][8] = ($urandom_range(99) < 95);
   endtask

   // Offer every queued byte, waiting on req_tready for each
   task automatic drain_outgoing();
      logic [9:0] beat;
      while (outgoing.size() != 0) begin
         beat = outgoing.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= beat[7:0];
         req_tuser  <= beat[8];
         req_tlast  <= beat[9];
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic run_random_phase(int unsigned idle, int unsigned stall, int unsigned bytes,
                                   bit hold);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      if (hold) hold_requests <= hold_requests + 1;
      while (outgoing.size() < bytes) add_request();
      drain_outgoing();
      wait_for_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: header end before any request start, ignored bytes after a summary,
      // empty method, first byte with end of data, restart in mid request
      add_text("\r\n\r\n");
      add_byte("G", 1'b1);
      add_text(" / \r\n\r\n");
      add_byte(8'hFF);
      add_byte(8'h00, 1'b0, 1'b1);
      add_byte(CH_SPACE, 1'b1);
      add_byte("x", 1'b0, 1'b1);
      add_byte(8'h80, 1'b1, 1'b1);
      add_byte("A", 1'b1);
      add_byte(CH_CR, 1'b1);
      add_text("\n\r\n");
      drain_outgoing();
      wait_for_results();

      // longest good path, path too long
      add_byte("M", 1'b1);
      add_byte(CH_SPACE);
      repeat (255) add_byte("p");
      add_text(" \r\n\r\n");
      add_byte("M", 1'b1);
      add_byte(CH_SPACE);
      repeat (256) add_byte("p");
      add_text(" \r\n\r\n");
      drain_outgoing();
      wait_for_results();

      // random traffic under each idling pattern; the first one with a long hold-off
      run_random_phase(0, 0, 320, 1'b1);
      run_random_phase(57, 0, 320, 1'b0);
      run_random_phase(0, 57, 320, 1'b0);
      run_random_phase(21, 21, 320, 1'b0);

      rsp_stall_pct = 0;
      wait_for_results();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("http_request_header_parser_top regression: pass");
      end else begin
         $display("http_request_header_parser_top regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
src/hrp_pkg.sv
src/hrp_line_scan.sv
src/http_request_header_parser_top.sv
src/hrp_checker.sv
tb/sv/testbench.sv
